FILE: rtl/core/fixed_block_pool_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define FBPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another on the same edge, outside reset.
`define FBPA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fbpa_pkg.sv
// Types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned UNIT_COUNT_W = 9;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned ID_W         = 8;
  localparam int unsigned USED_W       = 9;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_ALLOC = 2'd0;
  localparam kind_t KIND_FREE  = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

endpackage

FILE: rtl/core/fbpa_req_if.sv
// Request channel of the allocator: kind and unit id with valid and ready.
interface fbpa_req_if;
  logic                          valid;
  logic                          ready;
  fbpa_pkg::kind_t               kind;
  logic [fbpa_pkg::ID_W-1:0]     unit_id;

  modport source (output valid, kind, unit_id, input ready);
  modport sink   (input valid, kind, unit_id, output ready);
endinterface

FILE: rtl/core/fbpa_rsp_if.sv
// Response channel of the allocator: status, unit id and used count.
interface fbpa_rsp_if;
  logic                          valid;
  logic                          ready;
  fbpa_pkg::status_e             status;
  logic [fbpa_pkg::ID_W-1:0]     result_id;
  logic [fbpa_pkg::USED_W-1:0]   used_count;

  modport source (output valid, status, result_id, used_count, input ready);
  modport sink   (input valid, status, result_id, used_count, output ready);
endinterface

FILE: rtl/core/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO free list of unit ids with allocation marks.
// Throughput: one item per cycle while responses are taken; each item makes one pass
// through the stage register, the pop/push logic on the free-list RAM and the result
// register, where a result is held while the response is not taken.
// Reset: pool holds min(256, MAX_UNITS) free units, nothing allocated, ready at once.
// A unit_count write reinitializes the pool registers directly; no RAM clearing pass.
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator #(
  parameter int unsigned MAX_UNITS = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fbpa_pkg::UNIT_COUNT_W-1:0]     cfg_wdata_i,
  fbpa_req_if.sink                              req_i,
  fbpa_rsp_if.source                            rsp_o
);

  localparam int unsigned CW      = $clog2(MAX_UNITS + 1);
  localparam int unsigned IW      = $clog2(MAX_UNITS);
  localparam int unsigned VW      = (CW > fbpa_pkg::UNIT_COUNT_W) ? CW
                                                                  : fbpa_pkg::UNIT_COUNT_W;
  localparam int unsigned RESET_N = (MAX_UNITS < 256) ? MAX_UNITS : 256;

  // Pool state
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] lw_q, lw_d;
  logic [CW-1:0] total_q, total_d;

  // Stage register
  logic                          s1_valid_q;
  fbpa_pkg::kind_t               s1_kind_q;
  logic [fbpa_pkg::ID_W-1:0]     s1_id_q;

  // Result register
  logic                          rsp_valid_q;
  fbpa_pkg::status_e             status_q, status_d;
  logic [fbpa_pkg::ID_W-1:0]     rid_q, rid_d;
  logic [fbpa_pkg::USED_W-1:0]   used_q, used_d;

  logic out_free, s1_adv, in_fire;

  // Free-list RAM
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr, stk_rdata, stk_fwd_q;
  logic          stk_fwd_hit_q;

  // Allocation mark RAM
  logic          mark_we, mark_wdata, mark_rdata, mark_fwd_q, mark_fwd_hit_q;
  logic [IW-1:0] mark_waddr, mark_raddr;

  logic [VW-1:0] cfg_ext, n_cfg_ext, id_ext, u_ext, tot_ext;
  logic [CW-1:0] n_cfg, touched;
  logic [IW-1:0] id_idx, u_new, stk_top;
  logic          in_range, marked;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign in_fire     = req_i.valid && req_i.ready;

  // Clamp the written unit count to 1..MAX_UNITS
  always_comb begin
    cfg_ext = VW'(cfg_wdata_i);
    priority if (cfg_ext == '0) begin
      n_cfg_ext = VW'(1);
    end else if (cfg_ext > VW'(MAX_UNITS)) begin
      n_cfg_ext = VW'(MAX_UNITS);
    end else begin
      n_cfg_ext = cfg_ext;
    end
    n_cfg = CW'(n_cfg_ext);
  end

  // Lookups for the item in the stage register
  assign id_ext   = VW'(s1_id_q);
  assign id_idx   = IW'(s1_id_q);
  assign touched  = CW'(n_q - lw_q);
  assign in_range = id_ext < VW'(n_q);
  assign marked   = (id_ext < VW'(touched)) &&
                    (mark_fwd_hit_q ? mark_fwd_q : mark_rdata);
  assign stk_top  = stk_fwd_hit_q ? stk_fwd_q : stk_rdata;

  always_comb begin
    n_d        = n_q;
    depth_d    = depth_q;
    lw_d       = lw_q;
    total_d    = total_q;
    stk_we     = 1'b0;
    stk_waddr  = IW'(depth_q);
    mark_we    = 1'b0;
    mark_waddr = id_idx;
    mark_wdata = 1'b0;
    status_d   = fbpa_pkg::ST_OK;
    rid_d      = s1_id_q;
    u_new      = stk_top;
    u_ext      = '0;
    if (cfg_we_i) begin
      n_d     = n_cfg;
      depth_d = n_cfg;
      lw_d    = n_cfg;
      total_d = '0;
    end else if (s1_adv) begin
      unique case (s1_kind_q)
        fbpa_pkg::KIND_ALLOC: begin
          if (depth_q == '0) begin
            status_d = fbpa_pkg::ST_EMPTY;
            rid_d    = '0;
          end else begin
            if (depth_q == lw_q) begin
              u_new = IW'(n_q - depth_q);
              lw_d  = lw_q - CW'(1);
            end
            depth_d    = depth_q - CW'(1);
            total_d    = total_q + CW'(1);
            mark_we    = 1'b1;
            mark_waddr = u_new;
            mark_wdata = 1'b1;
            u_ext      = VW'(u_new);
            rid_d      = u_ext[fbpa_pkg::ID_W-1:0];
          end
        end
        fbpa_pkg::KIND_FREE: begin
          if (!in_range) begin
            status_d = fbpa_pkg::ST_RANGE;
          end else if (!marked) begin
            status_d = fbpa_pkg::ST_NOT_ALLOC;
          end else begin
            stk_we  = 1'b1;
            depth_d = depth_q + CW'(1);
            total_d = total_q - CW'(1);
            mark_we = 1'b1;
          end
        end
        default: begin
          if (!in_range) begin
            status_d = fbpa_pkg::ST_RANGE;
          end else if (!marked) begin
            status_d = fbpa_pkg::ST_NOT_ALLOC;
          end
        end
      endcase
    end
    tot_ext = VW'(total_d);
    used_d  = tot_ext[fbpa_pkg::USED_W-1:0];
  end

  assign stk_raddr  = IW'(depth_d - CW'(1));
  assign mark_raddr = in_fire ? IW'(req_i.unit_id) : id_idx;

  fbpa_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_UNITS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (id_idx),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  fbpa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_UNITS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q            <= CW'(RESET_N);
      depth_q        <= CW'(RESET_N);
      lw_q           <= CW'(RESET_N);
      total_q        <= '0;
      s1_valid_q     <= 1'b0;
      rsp_valid_q    <= 1'b0;
      stk_fwd_hit_q  <= 1'b0;
      mark_fwd_hit_q <= 1'b0;
    end else begin
      n_q            <= n_d;
      depth_q        <= depth_d;
      lw_q           <= lw_d;
      total_q        <= total_d;
      stk_fwd_hit_q  <= stk_we && (stk_waddr == stk_raddr);
      mark_fwd_hit_q <= mark_we && (mark_waddr == mark_raddr);
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_free) begin
        rsp_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    stk_fwd_q  <= id_idx;
    mark_fwd_q <= mark_wdata;
    if (in_fire) begin
      s1_kind_q <= req_i.kind;
      s1_id_q   <= req_i.unit_id;
    end
    if (s1_adv) begin
      status_q <= status_d;
      rid_q    <= rid_d;
      used_q   <= used_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.result_id  = rid_q;
  assign rsp_o.used_count = used_q;

  `FBPA_ASSERT(a_count_sum, clk_i, rst_ni, ((depth_q + total_q) == n_q), "free plus used differs from pool size")
  `FBPA_ASSERT(a_low_water, clk_i, rst_ni, (lw_q <= depth_q), "low-water mark above free depth")
  `FBPA_ASSERT_IMPLIES(a_empty_depth, clk_i, rst_ni, rsp_valid_q && (status_q == fbpa_pkg::ST_EMPTY), depth_q == '0, "empty reported with free units left")
  `FBPA_ASSERT(a_stage_hold, clk_i, rst_ni, (s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_id_q)), "stalled item left the stage register")

endmodule

FILE: rtl/core/fbpa_ram.sv
// Simple dual-port RAM, one write and one registered read port, read-first.
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the fixed block pool allocator: predicted results checked against the response.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned     ID_W         = fbpa_pkg::ID_W;
  localparam int unsigned     USED_W       = fbpa_pkg::USED_W;
  localparam int unsigned     UNIT_COUNT_W = fbpa_pkg::UNIT_COUNT_W;
  localparam fbpa_pkg::kind_t KIND_SPARE   = 2'd3;
  localparam int unsigned     POOL_MAX     = 256;
  localparam int unsigned     CYCLE_LIMIT  = 200000;
  localparam int unsigned     PHASE_ITEMS  = 45;

  typedef struct packed {
    fbpa_pkg::status_e      status;
    logic [ID_W-1:0]        result_id;
    logic [USED_W-1:0]      used_count;
  } pool_result_t;

  typedef struct packed {
    fbpa_pkg::kind_t        kind;
    logic [ID_W-1:0]        unit_id;
    pool_result_t           outcome;
  } pool_request_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [UNIT_COUNT_W-1:0] cfg_wdata_i;

  fbpa_req_if req_if ();
  fbpa_rsp_if rsp_if ();

  fixed_block_pool_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // pool model
  logic [ID_W-1:0] free_ids [POOL_MAX];
  logic            held [POOL_MAX];
  int unsigned     free_top;
  int unsigned     used_total;
  int unsigned     unit_limit;

  pool_request_t   request_q [$];
  pool_result_t    awaited_q [$];
  pool_request_t   on_bus;

  int unsigned     cycle_cnt;
  int unsigned     error_cnt = 0;
  int unsigned     result_cnt = 0;
  int unsigned     empty_cnt = 0;
  int unsigned     queued_cnt;
  int unsigned     size_cnt;
  int unsigned     burst_left;
  int unsigned     gap_left;
  int unsigned     stall_mode;

  function automatic void pool_reinit(int unsigned value);
    int unsigned n;
    n = (value == 0) ? 1 : ((value > POOL_MAX) ? POOL_MAX : value);
    for (int unsigned i = 0; i < POOL_MAX; i++) begin
      held[i] = 1'b0;
      if (i < n) begin
        free_ids[i] = ID_W'(n - 1 - i);
      end
    end
    free_top   = n;
    used_total = 0;
    unit_limit = n;
  endfunction

  function automatic pool_result_t apply_pool_request(fbpa_pkg::kind_t kind,
                                                      logic [ID_W-1:0] id);
    pool_result_t r;
    r.status    = fbpa_pkg::ST_OK;
    r.result_id = id;
    if (kind == fbpa_pkg::KIND_ALLOC) begin
      if (free_top == 0) begin
        r.status    = fbpa_pkg::ST_EMPTY;
        r.result_id = '0;
      end else begin
        free_top--;
        r.result_id = free_ids[free_top];
        held[free_ids[free_top]] = 1'b1;
        used_total++;
      end
    end else if (id >= unit_limit) begin
      r.status = fbpa_pkg::ST_RANGE;
    end else if (!held[id]) begin
      r.status = fbpa_pkg::ST_NOT_ALLOC;
    end else if (kind == fbpa_pkg::KIND_FREE) begin
      free_ids[free_top] = id;
      free_top++;
      held[id] = 1'b0;
      used_total--;
    end
    r.used_count = USED_W'(used_total);
    return r;
  endfunction

  task automatic queue_request(fbpa_pkg::kind_t kind, logic [ID_W-1:0] id);
    pool_request_t req;
    req.kind    = kind;
    req.unit_id = id;
    req.outcome = apply_pool_request(kind, id);
    request_q.push_back(req);
    queued_cnt++;
  endtask

  function automatic logic [ID_W-1:0] pick_held_unit();
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, unit_limit - 1);
    for (int unsigned i = 0; i < unit_limit; i++) begin
      idx = (start + i) % unit_limit;
      if (held[idx]) begin
        return ID_W'(idx);
      end
    end
    return ID_W'(start);
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (request_q.size() != 0 || req_if.valid || awaited_q.size() != 0 ||
               result_cnt < queued_cnt);
  endtask

  task automatic write_unit_count(int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= UNIT_COUNT_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_reinit(value);
    size_cnt++;
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned alloc_bias;
    int unsigned sel;
    alloc_bias = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 15 == 0) begin
        alloc_bias = 20 + 30 * $urandom_range(0, 2);
      end
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        queue_request(fbpa_pkg::kind_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 255)));
      end else if (sel < 22) begin
        queue_request($urandom_range(0, 1) ? fbpa_pkg::KIND_QUERY : KIND_SPARE,
                      ID_W'($urandom_range(0, unit_limit - 1)));
      end else if ($urandom_range(0, 99) < alloc_bias) begin
        queue_request(fbpa_pkg::KIND_ALLOC, ID_W'($urandom_range(0, 255)));
      end else begin
        queue_request(fbpa_pkg::KIND_FREE, pick_held_unit());
      end
    end
  endtask

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results still awaited",
                 cycle_cnt, awaited_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.kind    <= fbpa_pkg::KIND_ALLOC;
      req_if.unit_id <= '0;
      burst_left     <= 1;
      gap_left       <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        awaited_q.push_back(on_bus.outcome);
      end
      if (gap_left == 0 && request_q.size() != 0) begin
        on_bus = request_q.pop_front();
        req_if.valid   <= 1'b1;
        req_if.kind    <= on_bus.kind;
        req_if.unit_id <= on_bus.unit_id;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_mode   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        result_cnt++;
        if (awaited_q.size() == 0) begin
          $error("Unexpected result: status %0d result_id %0d used_count %0d",
                 rsp_if.status, rsp_if.result_id, rsp_if.used_count);
          error_cnt++;
        end else begin
          want = awaited_q.pop_front();
          if (want.status == fbpa_pkg::ST_EMPTY) begin
            empty_cnt++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            error_cnt++;
          end
          if (rsp_if.result_id !== want.result_id) begin
            $error("result_id: expected %0d, actual %0d", want.result_id, rsp_if.result_id);
            error_cnt++;
          end
          if (rsp_if.used_count !== want.used_count) begin
            $error("used_count: expected %0d, actual %0d",
                   want.used_count, rsp_if.used_count);
            error_cnt++;
          end
        end
      end
      if (cycle_cnt % 83 == 0) begin
        stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
        0: begin
          rsp_if.ready <= 1'b1;
        end
        1: begin
          rsp_if.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp_if.ready <= (cycle_cnt % 7) < 3;
        end
        default: begin
          rsp_if.ready <= $urandom_range(0, 4) == 0;
        end
      endcase
    end
  end

  initial begin
    int unsigned cfg_plan [10];
    cfg_plan = '{8, 0, 256, 511, 3, 300, 0, 2, 255, 1};
    cfg_plan[6]    = $urandom_range(4, 40);
    queued_cnt     = 0;
    size_cnt       = 1;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    pool_reinit(POOL_MAX);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_request(fbpa_pkg::KIND_ALLOC, 8'd0);
    queue_request(fbpa_pkg::KIND_ALLOC, 8'd255);
    queue_request(fbpa_pkg::KIND_QUERY, 8'd0);
    queue_request(fbpa_pkg::KIND_QUERY, 8'd255);
    queue_request(fbpa_pkg::KIND_QUERY, 8'd2);
    queue_request(fbpa_pkg::KIND_FREE, 8'd0);
    queue_request(fbpa_pkg::KIND_FREE, 8'd0);
    queue_request(fbpa_pkg::KIND_ALLOC, 8'd77);
    queue_request(KIND_SPARE, 8'd1);
    queue_request(fbpa_pkg::KIND_FREE, 8'd1);
    queue_request(fbpa_pkg::KIND_FREE, 8'd255);
    queue_request(fbpa_pkg::KIND_FREE, 8'd0);

    write_unit_count(1);
    queue_request(fbpa_pkg::KIND_ALLOC, 8'd0);
    queue_request(fbpa_pkg::KIND_ALLOC, 8'd0);
    queue_request(fbpa_pkg::KIND_FREE, 8'd1);
    queue_request(fbpa_pkg::KIND_QUERY, 8'd255);
    queue_request(fbpa_pkg::KIND_FREE, 8'd0);
    queue_request(fbpa_pkg::KIND_QUERY, 8'd0);

    foreach (cfg_plan[p]) begin
      write_unit_count(cfg_plan[p]);
      queue_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d results across %0d pool sizes, %0d refused for an empty pool",
             result_cnt, size_cnt, empty_cnt);
    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_req_if.sv
rtl/core/fbpa_rsp_if.sv
rtl/core/fbpa_ram.sv
rtl/core/fixed_block_pool_allocator.sv
tb/sv/tb_top.sv
